// File: rtl/core/wss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants for the wiper servo sweep controller
// Mode and interval codes, register indexes, servo and hold constants.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int KnobW   = 12;
   localparam int DwellW  = 14;
   localparam int TotalW  = 15;
   localparam int PosW    = 4;
   localparam int PulseW  = 14;
   localparam int HoldW   = 5;
   localparam int CsrIdxW = 8;
   localparam int CsrDatW = 14;

   localparam logic [PulseW-1:0] PulseBase    = 14'd5000;
   localparam logic [PulseW-1:0] PulsePerStep = 14'd668;
   localparam logic [HoldW-1:0]  HoldLow      = 5'd27;
   localparam logic [HoldW-1:0]  HoldHigh     = 5'd18;
   localparam logic [HoldW-1:0]  HoldDwell    = 5'd10;
   localparam logic [HoldW-1:0]  HoldOff      = 5'd0;
   localparam logic [TotalW-1:0] DwellAdd     = 15'd20;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_INTER = 2'd1,
      MODE_LOW   = 2'd2,
      MODE_HIGH  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      IVAL_SHORT  = 2'd0,
      IVAL_MEDIUM = 2'd1,
      IVAL_LONG   = 2'd2
   } ival_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_OFF_LIMIT    = 8'd0,
      CSR_INTER_LIMIT  = 8'd1,
      CSR_LOW_LIMIT    = 8'd2,
      CSR_SHORT_LIMIT  = 8'd3,
      CSR_MEDIUM_LIMIT = 8'd4,
      CSR_DWELL_SHORT  = 8'd5,
      CSR_DWELL_MEDIUM = 8'd6,
      CSR_DWELL_LONG   = 8'd7
   } csr_index_type;

   typedef struct packed {
      logic [KnobW-1:0]  off_limit;
      logic [KnobW-1:0]  inter_limit;
      logic [KnobW-1:0]  low_limit;
      logic [KnobW-1:0]  short_limit;
      logic [KnobW-1:0]  medium_limit;
      logic [DwellW-1:0] dwell_short;
      logic [DwellW-1:0] dwell_medium;
      logic [DwellW-1:0] dwell_long;
   } cfg_type;

   typedef struct packed {
      logic [PosW-1:0]   position_step;
      logic              returning;
      logic              sweep_done;
      logic [TotalW-1:0] dwell_total;
   } state_type;

   typedef struct packed {
      logic              ignition_on;
      logic [KnobW-1:0]  wiper_knob;
      logic [KnobW-1:0]  interval_knob;
   } update_type;

   typedef struct packed {
      logic [PulseW-1:0] pulse_tenths_us;
      logic [HoldW-1:0]  hold_ms;
      mode_type          wiper_mode;
      ival_type          interval_mode;
      logic              dwelling;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/core/wiper_servo_sweep_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wiper_servo_sweep_controller: wiper mode decode and servo sweep sequencing
// Takes periodic knob updates, returns servo pulse width and hold time.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one update item per handshake (ignition flag, mode knob,
//            interval knob).
//   rsp_*  : exactly one result item per update, in order (pulse width in
//            0.1 us units, hold in ms, decoded modes, dwell flag).
//   csr_*  : register writes, index 0..7 as listed in wss_pkg; higher
//            indexes are dropped. Always ready. Write only while idle.
// Path: an accepted item passes the input register, then the result
//   register, where rsp_tvalid rises. Throughput: one item per cycle
//   while rsp_tready is high; the servo state register updates in the
//   same cycle the item moves into the result register, so back-to-back
//   items see each other's effect.
// Reset (synchronous, active high): both stages empty, servo at rest,
//   dwell total and sweep flag cleared, registers back to their defaults.
// Stall: while rsp_tready is low the result holds; one more item can sit
//   in the input register, after which req_tready drops.
// ----------------------------------------------------------------------------
module wiper_servo_sweep_controller #(
   parameter int TOP_STEP  = 10,
   parameter int KNOB_BITS = 12
) (
   input  wire         clock,
   input  wire         reset,
   // request: [0] ignition_on, [12:1] wiper_knob, [24:13] interval_knob
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,
   // response: [13:0] pulse_tenths_us, [18:14] hold_ms, [20:19] wiper_mode,
   //           [22:21] interval_mode, [23] dwelling
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,
   // register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [wss_pkg::CsrIdxW-1:0] csr_index,
   input  wire  [wss_pkg::CsrDatW-1:0] csr_data
);
   import wss_pkg::*;

   localparam cfg_type CfgReset = '{
      off_limit:    12'd1024,
      inter_limit:  12'd2048,
      low_limit:    12'd3072,
      short_limit:  12'd1352,
      medium_limit: 12'd2703,
      dwell_short:  14'd3000,
      dwell_medium: 14'd6000,
      dwell_long:   14'd8000
   };

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_nxt;
   update_type upd_ff;
   logic       upd_valid_ff;
   result_type res_ff, res_nxt;
   logic       res_valid_ff;
   logic       res_load;
   logic       advance;

   // Result register loads when empty or being drained.
   assign res_load   = !res_valid_ff || rsp_tready;
   assign advance    = upd_valid_ff && res_load;
   assign req_tready = !upd_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Register write decode; data beyond a register's width is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OFF_LIMIT:    cfg_in.off_limit    = csr_data[KnobW-1:0];
            CSR_INTER_LIMIT:  cfg_in.inter_limit  = csr_data[KnobW-1:0];
            CSR_LOW_LIMIT:    cfg_in.low_limit    = csr_data[KnobW-1:0];
            CSR_SHORT_LIMIT:  cfg_in.short_limit  = csr_data[KnobW-1:0];
            CSR_MEDIUM_LIMIT: cfg_in.medium_limit = csr_data[KnobW-1:0];
            CSR_DWELL_SHORT:  cfg_in.dwell_short  = csr_data;
            CSR_DWELL_MEDIUM: cfg_in.dwell_medium = csr_data;
            CSR_DWELL_LONG:   cfg_in.dwell_long   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   wss_step #(
      .TOP_STEP  (TOP_STEP),
      .KNOB_BITS (KNOB_BITS)
   ) u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .upd (upd_ff),
      .nxt (state_nxt),
      .res (res_nxt)
   );

   // Control state and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CfgReset;
         state_ff     <= '0;
         upd_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_tready) begin
            upd_valid_ff <= req_tvalid;
         end
         if (res_load) begin
            res_valid_ff <= upd_valid_ff;
         end
         // Advance the servo state only as the item commits to a result.
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Payload: capture the update, hold the result while stalled.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         upd_ff.ignition_on   <= req_tdata[0];
         upd_ff.wiper_knob    <= req_tdata[12:1];
         upd_ff.interval_knob <= req_tdata[24:13];
      end
      if (advance) begin
         res_ff <= res_nxt;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {res_ff.dwelling,
                        res_ff.interval_mode,
                        res_ff.wiper_mode,
                        res_ff.hold_ms,
                        res_ff.pulse_tenths_us};

endmodule
`default_nettype wire

// File: rtl/core/wss_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wss_step: one update of the sweep controller
// Decode knobs, step the servo or dwell, form next state and the result.
// ----------------------------------------------------------------------------
module wss_step #(
   parameter int TOP_STEP  = 10,
   parameter int KNOB_BITS = 12
) (
   input  wire  wss_pkg::cfg_type    cfg,
   input  wire  wss_pkg::state_type  cur,
   input  wire  wss_pkg::update_type upd,
   output wss_pkg::state_type        nxt,
   output wss_pkg::result_type       res
);
   import wss_pkg::*;

   localparam logic [KnobW-1:0] KnobMask =
      (KNOB_BITS >= KnobW) ? {KnobW{1'b1}} : KnobW'((1 << KNOB_BITS) - 1);
   localparam logic [PosW-1:0] TopStep = PosW'(TOP_STEP);

   logic [KnobW-1:0]  wk;
   logic [KnobW-1:0]  ik;
   mode_type          mode;
   ival_type          ival;
   logic [DwellW-1:0] need;
   logic              marks;
   logic              pause;
   state_type         mv;
   logic [PosW-1:0]   pos_up;

   assign wk = upd.wiper_knob & KnobMask;
   assign ik = upd.interval_knob & KnobMask;

   // Priority decode, ignition off forces off and long.
   always_comb begin
      if (!upd.ignition_on)            mode = MODE_OFF;
      else if (wk <= cfg.off_limit)    mode = MODE_OFF;
      else if (wk <= cfg.inter_limit)  mode = MODE_INTER;
      else if (wk <= cfg.low_limit)    mode = MODE_LOW;
      else                             mode = MODE_HIGH;

      if (!upd.ignition_on)            ival = IVAL_LONG;
      else if (ik <= cfg.short_limit)  ival = IVAL_SHORT;
      else if (ik <= cfg.medium_limit) ival = IVAL_MEDIUM;
      else                             ival = IVAL_LONG;
   end

   always_comb begin
      case (ival)
         IVAL_SHORT:  need = cfg.dwell_short;
         IVAL_MEDIUM: need = cfg.dwell_medium;
         default:     need = cfg.dwell_long;
      endcase
   end

   // High mode does not mark a completed revolution.
   assign marks  = (mode != MODE_HIGH);
   assign pause  = (mode == MODE_INTER) && cur.sweep_done &&
                   ({1'b0, need} > cur.dwell_total);
   assign pos_up = cur.position_step + 1'b1;

   // Servo step: up past the top, then back down to rest.
   always_comb begin
      mv = cur;
      if (marks) begin
         mv.sweep_done = 1'b0;
      end
      if (!cur.returning) begin
         mv.position_step = pos_up;
         if (pos_up > TopStep) begin
            mv.returning = 1'b1;
         end
      end else if (cur.position_step == '0) begin
         mv.returning = 1'b0;
         if (marks) begin
            mv.sweep_done = 1'b1;
         end
      end else begin
         mv.position_step = cur.position_step - 1'b1;
      end
   end

   always_comb begin
      nxt          = cur;
      res.dwelling = 1'b0;
      case (mode)
         MODE_OFF: begin
            nxt.position_step = '0;
            nxt.returning     = 1'b0;
            res.hold_ms       = HoldOff;
         end
         MODE_INTER: begin
            if (pause) begin
               nxt.dwell_total = cur.dwell_total + DwellAdd;
               res.hold_ms     = HoldDwell;
               res.dwelling    = 1'b1;
            end else begin
               nxt             = mv;
               nxt.dwell_total = '0;
               res.hold_ms     = HoldLow;
            end
         end
         MODE_LOW: begin
            nxt         = mv;
            res.hold_ms = HoldLow;
         end
         default: begin
            nxt         = mv;
            res.hold_ms = HoldHigh;
         end
      endcase
      res.pulse_tenths_us = PulseBase +
                            PulsePerStep * PulseW'(nxt.position_step);
      res.wiper_mode      = mode;
      res.interval_mode   = ival;
   end

endmodule
`default_nettype wire

// File: verif/wiper_servo_sweep_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wiper_servo_sweep_controller_tb: self-checking bench for the sweep controller
// Drives knob updates and register writes with random handshake gaps and
// checks every result item against a cycle-free prediction of the servo
// sweep, the intermittent dwell and the mode and interval decode.
// ----------------------------------------------------------------------------
module wiper_servo_sweep_controller_tb;
   import wss_pkg::*;

   localparam int TopStep     = 10;
   localparam int KnobBits    = 12;
   localparam int KnobMax     = (1 << KnobBits) - 1;
   localparam int IdlePercent = 21;
   localparam int HoldOffLen  = 40;
   localparam int DrainCycles = 8;
   localparam int CycleLimit  = 200000;
   // first index past the register file; writes at or above it are dropped
   localparam int CsrPastEnd  = 8;
   localparam int CsrIdxMax   = (1 << CsrIdxW) - 1;

   // -------------------------------------------------------------------------
   // Sweep predictor and store of expected results
   // -------------------------------------------------------------------------
   class sweep_scoreboard;
      cfg_type           regs;
      int                top_step;
      logic [PosW-1:0]   position;
      logic              returning;
      logic              sweep_marked;
      logic [TotalW-1:0] dwell_sum;
      result_type        expected_results[$];
      int                mismatches;
      int                checked;

      function new(int top);
         top_step     = top;
         regs.off_limit    = 12'd1024;
         regs.inter_limit  = 12'd2048;
         regs.low_limit    = 12'd3072;
         regs.short_limit  = 12'd1352;
         regs.medium_limit = 12'd2703;
         regs.dwell_short  = 14'd3000;
         regs.dwell_medium = 14'd6000;
         regs.dwell_long   = 14'd8000;
         position     = '0;
         returning    = 1'b0;
         sweep_marked = 1'b0;
         dwell_sum    = '0;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDatW-1:0] data);
         case (idx)
            CSR_OFF_LIMIT:    regs.off_limit    = data[KnobW-1:0];
            CSR_INTER_LIMIT:  regs.inter_limit  = data[KnobW-1:0];
            CSR_LOW_LIMIT:    regs.low_limit    = data[KnobW-1:0];
            CSR_SHORT_LIMIT:  regs.short_limit  = data[KnobW-1:0];
            CSR_MEDIUM_LIMIT: regs.medium_limit = data[KnobW-1:0];
            CSR_DWELL_SHORT:  regs.dwell_short  = data;
            CSR_DWELL_MEDIUM: regs.dwell_medium = data;
            CSR_DWELL_LONG:   regs.dwell_long   = data;
            default: ;
         endcase
      endfunction

      // one servo step; low and intermittent sweeps mark the return to rest
      function void advance_servo(bit marks_sweep);
         if (marks_sweep) sweep_marked = 1'b0;
         if (!returning) begin
            position = position + 1'b1;
            if (position > top_step) returning = 1'b1;
         end else if (position == '0) begin
            returning = 1'b0;
            if (marks_sweep) sweep_marked = 1'b1;
         end else begin
            position = position - 1'b1;
         end
      endfunction

      function void note_update(update_type u);
         mode_type          mode;
         ival_type          ival;
         logic [DwellW-1:0] need;
         result_type        r;
         if (u.wiper_knob <= regs.off_limit) mode = MODE_OFF;
         else if (u.wiper_knob <= regs.inter_limit) mode = MODE_INTER;
         else if (u.wiper_knob <= regs.low_limit) mode = MODE_LOW;
         else mode = MODE_HIGH;
         if (u.interval_knob <= regs.short_limit) ival = IVAL_SHORT;
         else if (u.interval_knob <= regs.medium_limit) ival = IVAL_MEDIUM;
         else ival = IVAL_LONG;
         if (!u.ignition_on) begin
            mode = MODE_OFF;
            ival = IVAL_LONG;
         end
         r.dwelling = 1'b0;
         case (mode)
            MODE_OFF: begin
               position  = '0;
               returning = 1'b0;
               r.hold_ms = HoldOff;
            end
            MODE_INTER: begin
               case (ival)
                  IVAL_SHORT:  need = regs.dwell_short;
                  IVAL_MEDIUM: need = regs.dwell_medium;
                  default:     need = regs.dwell_long;
               endcase
               if (sweep_marked && dwell_sum < need) begin
                  dwell_sum  = dwell_sum + DwellAdd;
                  r.hold_ms  = HoldDwell;
                  r.dwelling = 1'b1;
               end else begin
                  advance_servo(1'b1);
                  dwell_sum = '0;
                  r.hold_ms = HoldLow;
               end
            end
            MODE_LOW: begin
               advance_servo(1'b1);
               r.hold_ms = HoldLow;
            end
            default: begin
               advance_servo(1'b0);
               r.hold_ms = HoldHigh;
            end
         endcase
         r.pulse_tenths_us = PulseBase + PulsePerStep * position;
         r.wiper_mode      = mode;
         r.interval_mode   = ival;
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string field, int unsigned want, int unsigned got);
         $display("[%0t] result %0d: %s expected %0d got %0d",
                  $time, checked, field, want, got);
         mismatches++;
      endtask

      task check_result(logic [23:0] d);
         result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("item with nothing outstanding, tdata", 0, 32'(d));
         end else begin
            want = expected_results.pop_front();
            if (d[13:0] !== want.pulse_tenths_us)
               report_mismatch("pulse_tenths_us", 32'(want.pulse_tenths_us),
                               32'(d[13:0]));
            if (d[18:14] !== want.hold_ms)
               report_mismatch("hold_ms", 32'(want.hold_ms), 32'(d[18:14]));
            if (d[20:19] !== want.wiper_mode)
               report_mismatch("wiper_mode", 32'(want.wiper_mode), 32'(d[20:19]));
            if (d[22:21] !== want.interval_mode)
               report_mismatch("interval_mode", 32'(want.interval_mode),
                               32'(d[22:21]));
            if (d[23] !== want.dwelling)
               report_mismatch("dwelling", 32'(want.dwelling), 32'(d[23]));
         end
         checked++;
      endtask

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // [0] ignition_on, [12:1] wiper_knob, [24:13] interval_knob
   logic [31:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [13:0] pulse_tenths_us, [18:14] hold_ms, [20:19] wiper_mode,
   // [22:21] interval_mode, [23] dwelling
   logic [23:0]         rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDatW-1:0]  csr_data   = '0;

   sweep_scoreboard sb;
   bit  calm        = 1'b0;   // no idling on either side while set
   bit  squeezed    = 1'b0;   // long receiver hold-off already done
   int  holdoff_left = 0;
   int  results_seen = 0;
   int  cycle_count  = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   wiper_servo_sweep_controller #(
      .TOP_STEP  (TopStep),
      .KNOB_BITS (KnobBits)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Receiver: drive tready at the falling edge. Once, after enough results,
   // hold off for a long stretch so the result and input stages both fill
   // and req_tready has to drop while the sender keeps offering.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!squeezed && results_seen >= 120) begin
         squeezed     <= 1'b1;
         holdoff_left <= HoldOffLen - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
      end
   end

   // Check every result item at the edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
         results_seen <= results_seen + 1;
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------
   // Offer one update; called at a falling edge, returns at a falling edge.
   task automatic send_update(update_type u);
      while (!calm && $urandom_range(0, 99) < IdlePercent) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, u.interval_knob, u.wiper_knob, u.ignition_on};
      do @(posedge clock); while (!req_tready);
      sb.note_update(u);
      @(negedge clock);
   endtask

   task automatic probe(bit ign, int wk, int ik);
      update_type u;
      u.ignition_on   = ign;
      u.wiper_knob    = KnobW'(wk);
      u.interval_knob = KnobW'(ik);
      send_update(u);
   endtask

   // Drop valid, let every outstanding result drain, then allow for latency.
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDatW-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Write the whole register file, then one out-of-range index that the
   // block must drop.
   task automatic configure(int offl, int interl, int lowl, int shortl, int medl,
                            int ds, int dm, int dl);
      wait_idle();
      csr_write(CSR_OFF_LIMIT, CsrDatW'(offl));
      csr_write(CSR_INTER_LIMIT, CsrDatW'(interl));
      csr_write(CSR_LOW_LIMIT, CsrDatW'(lowl));
      csr_write(CSR_SHORT_LIMIT, CsrDatW'(shortl));
      csr_write(CSR_MEDIUM_LIMIT, CsrDatW'(medl));
      csr_write(CSR_DWELL_SHORT, CsrDatW'(ds));
      csr_write(CSR_DWELL_MEDIUM, CsrDatW'(dm));
      csr_write(CSR_DWELL_LONG, CsrDatW'(dl));
      csr_write(CsrIdxW'($urandom_range(CsrPastEnd, CsrIdxMax)), CsrDatW'($urandom));
      csr_valid = 1'b0;
   endtask

   // Ordered random limits with junk in the bits above the 12-bit fields,
   // and dwells short enough for intermittent runs to finish a pause.
   task automatic shuffle_config(int dwell_cap);
      int a, b, c, s, m;
      a = $urandom_range(200, 1500);
      b = $urandom_range(a + 1, 2800);
      c = $urandom_range(b + 1, 4000);
      s = $urandom_range(100, 2000);
      m = $urandom_range(s + 1, 4000);
      configure(a | ($urandom_range(0, 3) << KnobW), b | ($urandom_range(0, 3) << KnobW),
                c | ($urandom_range(0, 3) << KnobW), s | ($urandom_range(0, 3) << KnobW),
                m | ($urandom_range(0, 3) << KnobW), $urandom_range(0, dwell_cap),
                $urandom_range(0, dwell_cap), $urandom_range(0, dwell_cap));
   endtask

   // Pick in [lo, hi]; an empty range (misordered limits) gives any value.
   function automatic logic [KnobW-1:0] pick_in(int lo, int hi);
      if (lo > hi) return KnobW'($urandom_range(0, KnobMax));
      return KnobW'($urandom_range(lo, hi));
   endfunction

   function automatic logic [KnobW-1:0] wiper_knob_for(mode_type m);
      int off_l, inter_l, low_l, floor_l;
      off_l   = int'(sb.regs.off_limit);
      inter_l = int'(sb.regs.inter_limit);
      low_l   = int'(sb.regs.low_limit);
      floor_l = (off_l > inter_l) ? off_l : inter_l;
      case (m)
         MODE_OFF:   return pick_in(0, off_l);
         MODE_INTER: return pick_in(off_l + 1, inter_l);
         MODE_LOW:   return pick_in(floor_l + 1, low_l);
         default:    return pick_in(((floor_l > low_l) ? floor_l : low_l) + 1, KnobMax);
      endcase
   endfunction

   function automatic logic [KnobW-1:0] interval_knob_for(ival_type iv);
      int short_l, medium_l;
      short_l  = int'(sb.regs.short_limit);
      medium_l = int'(sb.regs.medium_limit);
      case (iv)
         IVAL_SHORT:  return pick_in(0, short_l);
         IVAL_MEDIUM: return pick_in(short_l + 1, medium_l);
         default:     return pick_in(((short_l > medium_l) ? short_l : medium_l) + 1, KnobMax);
      endcase
   endfunction

   // Mostly runs that hold one mode and interval long enough to complete
   // sweeps and dwell pauses, with short bursts of arbitrary updates between.
   task automatic random_phase(int count);
      int         sent, run_len, k;
      mode_type   m;
      ival_type   iv;
      bit         ign;
      update_type u;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 80) begin
            m       = mode_type'($urandom_range(0, 3));
            iv      = ival_type'($urandom_range(0, 2));
            ign     = (m != MODE_OFF) || $urandom_range(0, 1);
            run_len = (m == MODE_OFF) ? $urandom_range(1, 6) : $urandom_range(10, 60);
            for (k = 0; k < run_len && sent < count; k++) begin
               u.ignition_on   = ign;
               u.wiper_knob    = wiper_knob_for(m);
               u.interval_knob = interval_knob_for(iv);
               send_update(u);
               sent++;
            end
         end else begin
            run_len = $urandom_range(1, 5);
            for (k = 0; k < run_len && sent < count; k++) begin
               u = update_type'(25'($urandom));
               send_update(u);
               sent++;
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new(TopStep);
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: ignition off overriding both knobs, every decode boundary
      // at the reset limits, and a drop to off or ignition off mid-sweep.
      probe(1'b0, KnobMax, 0);
      probe(1'b0, 0, KnobMax);
      probe(1'b1, 0, 0);
      probe(1'b1, 1024, 1352);
      probe(1'b1, 1025, 1353);
      probe(1'b1, 2048, 2703);
      probe(1'b1, 2049, 2704);
      probe(1'b1, 3072, KnobMax);
      probe(1'b1, 3073, 0);
      probe(1'b1, KnobMax, KnobMax);
      probe(1'b1, KnobMax, 1352);
      probe(1'b1, KnobMax, 2703);
      probe(1'b1, 1024, KnobMax);
      probe(1'b1, 2049, 0);
      probe(1'b1, 2049, 0);
      probe(1'b0, 2049, 0);
      probe(1'b1, 1025, 0);
      probe(1'b1, 1025, KnobMax);

      // Reset limits with short dwells so intermittent pauses complete.
      configure(1024, 2048, 3072, 1352, 2703, 40, 100, 200);
      random_phase(90);

      // Random limits, no idling on either side; the long receiver
      // hold-off lands in here while the sender offers every cycle.
      shuffle_config(400);
      calm = 1'b1;
      random_phase(90);
      calm = 1'b0;

      // All limits and dwells at zero: only off and high remain, no pause.
      configure(0, 0, 0, 0, 0, 0, 0, 0);
      random_phase(40);

      // All limits at full scale: everything decodes as off.
      configure(KnobMax, KnobMax, KnobMax, KnobMax, KnobMax, 16383, 16383, 16383);
      random_phase(20);

      // Intermittent almost everywhere, dwells at both ends.
      configure(0, KnobMax, KnobMax, 0, KnobMax, 16383, 16000, 0);
      random_phase(60);

      // Misordered limits: the decode falls through as a priority chain.
      configure(3000, 1000, 2000, 3000, 1000, $urandom_range(0, 300),
                $urandom_range(0, 300), $urandom_range(0, 300));
      random_phase(60);

      shuffle_config(600);
      random_phase(90);

      wait_idle();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
